[src/eye_signal_direction_classifier_macros.svh]
// Assertion macros shared by the checker of the eye signal direction classifier.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef EYE_SIGNAL_DIRECTION_CLASSIFIER_MACROS_SVH
`define EYE_SIGNAL_DIRECTION_CLASSIFIER_MACROS_SVH

// The consequent must hold in the cycle in which the antecedent ends.
`define ESDC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent ends.
`define ESDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/esdc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package esdc_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int SAMPLE_W     = 8;
    localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int MEAN_SHIFT   = $clog2(WINDOW_DEPTH + 1) - 1;

    localparam int REG_COUNT = 3;
    localparam int PADDR_W   = $clog2(REG_COUNT) + 2;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_REFERENCE_LEVEL = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD       = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT         = REG_IDX_W'(2);

    localparam logic [7:0] REFERENCE_RESET = 8'd0;
    localparam logic [6:0] THRESHOLD_RESET = 7'd25;
    localparam logic [9:0] TIMEOUT_RESET   = 10'd300;

    localparam logic [SAMPLE_W-1:0] ADC_MIN = 8'd0;
    localparam logic [SAMPLE_W-1:0] ADC_MAX = 8'd255;

    localparam logic signed [SUM_W-1:0] MEAN_MAX = SUM_W'(127);
    localparam logic signed [SUM_W-1:0] MEAN_MIN = SUM_W'(-128);
    localparam logic [7:0] MEAN_MAX_8 = 8'h7F;
    localparam logic [7:0] MEAN_MIN_8 = 8'h80;

    typedef enum logic [1:0] {
        DIR_REST  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_CLIP  = 2'd3
    } dir_t;

    typedef struct packed {
        logic [7:0] reference_level;
        logic [6:0] threshold;
        logic [9:0] timeout;
    } config_t;

    typedef struct packed {
        logic                    valid;
        logic                    clip;
        logic signed [SUM_W-1:0] sum;
    } window_status_t;

endpackage

`default_nettype wire

[src/esdc_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module esdc_cell (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  shift,
    input  logic signed [esdc_pkg::SAMPLE_W-1:0]  sample_next,
    output logic signed [esdc_pkg::SAMPLE_W-1:0]  sample_out
);

    logic signed [esdc_pkg::SAMPLE_W-1:0] sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else if (shift)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample_out = sample_reg;

endmodule

`default_nettype wire

[src/esdc_window.sv]
`timescale 1ns / 1ps
`default_nettype none

module esdc_window (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_accept,
    input  logic [esdc_pkg::SAMPLE_W-1:0]   adc_sample,
    input  logic [7:0]                      reference_level,
    input  logic                            take,
    output esdc_pkg::window_status_t        status
);

    logic signed [esdc_pkg::SAMPLE_W-1:0] tap [esdc_pkg::WINDOW_DEPTH+1];
    logic signed [esdc_pkg::SUM_W-1:0]    sum_reg;
    logic signed [esdc_pkg::SUM_W-1:0]    sum_next;
    logic                                 valid_reg;
    logic                                 clip_reg;

    assign tap[0] = adc_sample - reference_level;

    for (genvar i = 0; i < esdc_pkg::WINDOW_DEPTH; i++)
    begin : g_cell
        esdc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .shift       (sample_accept),
            .sample_next (tap[i]),
            .sample_out  (tap[i+1])
        );
    end

    // The sample leaving the last cell is the one the new sample replaces.
    assign sum_next = sum_reg + esdc_pkg::SUM_W'(tap[0])
                    - esdc_pkg::SUM_W'(tap[esdc_pkg::WINDOW_DEPTH]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            valid_reg <= 1'b0;
            clip_reg  <= 1'b0;
        end
        else if (sample_accept)
        begin
            sum_reg   <= sum_next;
            valid_reg <= 1'b1;
            clip_reg  <= (adc_sample == esdc_pkg::ADC_MIN) || (adc_sample == esdc_pkg::ADC_MAX);
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign status.valid = valid_reg;
    assign status.clip  = clip_reg;
    assign status.sum   = sum_reg;

endmodule

`default_nettype wire

[src/esdc_direction.sv]
`timescale 1ns / 1ps
`default_nettype none

module esdc_direction (
    input  logic                        clk,
    input  logic                        rst_n,
    input  esdc_pkg::window_status_t    status,
    input  esdc_pkg::config_t           cfg,
    input  logic                        result_stall,
    output logic                        take,
    output logic                        result_valid,
    output logic [1:0]                  direction,
    output logic signed [7:0]           window_mean
);

    logic signed [esdc_pkg::SUM_W-1:0] shifted;
    logic signed [7:0]                 mean;
    logic signed [7:0]                 thr_pos;
    logic signed [7:0]                 thr_neg;
    esdc_pkg::dir_t                    cls;
    esdc_pkg::dir_t                    dir_mid;
    esdc_pkg::dir_t                    dir_next;
    esdc_pkg::dir_t                    dir_reg;
    esdc_pkg::dir_t                    prev_class_reg;
    logic [9:0]                        hold_next;
    logic [9:0]                        hold_reg;
    logic                              result_valid_reg;
    logic signed [7:0]                 mean_reg;

    assign take = status.valid && !(result_valid_reg && result_stall);

    assign shifted = status.sum >>> esdc_pkg::MEAN_SHIFT;
    assign thr_pos = $signed({1'b0, cfg.threshold});
    assign thr_neg = -thr_pos;

    always_comb
    begin
        if (shifted > esdc_pkg::MEAN_MAX)
        begin
            mean = esdc_pkg::MEAN_MAX_8;
        end
        else if (shifted < esdc_pkg::MEAN_MIN)
        begin
            mean = esdc_pkg::MEAN_MIN_8;
        end
        else
        begin
            mean = shifted[7:0];
        end

        if (status.clip)
        begin
            cls = esdc_pkg::DIR_CLIP;
        end
        else if (mean > thr_pos)
        begin
            cls = esdc_pkg::DIR_LEFT;
        end
        else if (mean < thr_neg)
        begin
            cls = esdc_pkg::DIR_RIGHT;
        end
        else
        begin
            cls = esdc_pkg::DIR_REST;
        end
    end

    always_comb
    begin
        dir_mid = dir_reg;
        if (cls == esdc_pkg::DIR_CLIP)
        begin
            dir_mid = esdc_pkg::DIR_CLIP;
        end
        else if (prev_class_reg == esdc_pkg::DIR_CLIP)
        begin
            dir_mid = cls;
        end
        else if (prev_class_reg == esdc_pkg::DIR_REST && cls == esdc_pkg::DIR_LEFT)
        begin
            if (dir_reg == esdc_pkg::DIR_REST || dir_reg == esdc_pkg::DIR_LEFT)
            begin
                dir_mid = esdc_pkg::DIR_LEFT;
            end
            else if (dir_reg == esdc_pkg::DIR_RIGHT)
            begin
                dir_mid = esdc_pkg::DIR_REST;
            end
        end
        else if (prev_class_reg == esdc_pkg::DIR_REST && cls == esdc_pkg::DIR_RIGHT)
        begin
            if (dir_reg == esdc_pkg::DIR_REST || dir_reg == esdc_pkg::DIR_RIGHT)
            begin
                dir_mid = esdc_pkg::DIR_RIGHT;
            end
            else if (dir_reg == esdc_pkg::DIR_LEFT)
            begin
                dir_mid = esdc_pkg::DIR_REST;
            end
        end

        dir_next = dir_mid;
        if (dir_mid != dir_reg)
        begin
            hold_next = '0;
        end
        else if (hold_reg == cfg.timeout)
        begin
            hold_next = '0;
            if (dir_mid == esdc_pkg::DIR_LEFT || dir_mid == esdc_pkg::DIR_RIGHT)
            begin
                dir_next = esdc_pkg::DIR_REST;
            end
        end
        else
        begin
            hold_next = hold_reg + 10'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg          <= esdc_pkg::DIR_REST;
            prev_class_reg   <= esdc_pkg::DIR_REST;
            hold_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            dir_reg          <= dir_next;
            prev_class_reg   <= cls;
            hold_reg         <= hold_next;
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mean_reg <= mean;
        end
    end

    assign result_valid = result_valid_reg;
    assign direction    = dir_reg;
    assign window_mean  = mean_reg;

endmodule

`default_nettype wire

[src/esdc_apb.sv]
`timescale 1ns / 1ps
`default_nettype none

module esdc_apb (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [esdc_pkg::PADDR_W-1:0]    paddr,
    input  logic [esdc_pkg::PDATA_W-1:0]    pwdata,
    output logic [esdc_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    output esdc_pkg::config_t               cfg
);

    logic [esdc_pkg::REG_IDX_W-1:0] reg_idx;
    logic [7:0]                     reference_level_reg;
    logic [6:0]                     threshold_reg;
    logic [9:0]                     timeout_reg;
    logic                           write_en;

    assign reg_idx  = paddr[esdc_pkg::PADDR_W-1:2];
    assign pready   = 1'b1;
    assign write_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reference_level_reg <= esdc_pkg::REFERENCE_RESET;
            threshold_reg       <= esdc_pkg::THRESHOLD_RESET;
            timeout_reg         <= esdc_pkg::TIMEOUT_RESET;
        end
        else if (write_en)
        begin
            unique case (reg_idx)
                esdc_pkg::REG_REFERENCE_LEVEL: reference_level_reg <= pwdata[7:0];
                esdc_pkg::REG_THRESHOLD:       threshold_reg       <= pwdata[6:0];
                esdc_pkg::REG_TIMEOUT:         timeout_reg         <= pwdata[9:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            esdc_pkg::REG_REFERENCE_LEVEL: prdata = esdc_pkg::PDATA_W'(reference_level_reg);
            esdc_pkg::REG_THRESHOLD:       prdata = esdc_pkg::PDATA_W'(threshold_reg);
            esdc_pkg::REG_TIMEOUT:         prdata = esdc_pkg::PDATA_W'(timeout_reg);
            default:                       prdata = '0;
        endcase
    end

    assign cfg.reference_level = reference_level_reg;
    assign cfg.threshold       = threshold_reg;
    assign cfg.timeout         = timeout_reg;

endmodule

`default_nettype wire

[src/eye_signal_direction_classifier.sv]
// Eye signal direction classifier.
// Samples arrive on sample_valid / sample_stall with adc_sample as payload;
// a transfer takes place at a rising edge with valid high and stall low.
// Results leave on result_valid / result_stall carrying direction
// (0 rest, 1 left, 2 right, 3 clipping) and the signed window_mean.
// Each sample gives exactly one result, registered first in the window
// stage and then in the result registers. One sample per cycle is sustained
// while result_stall is low: the moving window is a chain of cells that
// shifts once per sample, and a running sum gives the mean directly.
// The APB port sets reference_level, threshold and timeout; pready is
// always high, and registers should only be written while the block is idle.
// Reset clears the window and its sum, sets the direction to rest with the
// hold counter at zero, and loads reference 0, threshold 25, timeout 300.
// While result_stall is high the result holds; one further sample can be
// taken into the window stage, after which sample_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module eye_signal_direction_classifier (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [esdc_pkg::PADDR_W-1:0]    paddr,
    input  logic [esdc_pkg::PDATA_W-1:0]    pwdata,
    output logic [esdc_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic [esdc_pkg::SAMPLE_W-1:0]   adc_sample,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [1:0]                      direction,
    output logic signed [7:0]               window_mean
);

    esdc_pkg::config_t        cfg;
    esdc_pkg::window_status_t status;
    logic                     sample_accept;
    logic                     take;

    assign sample_stall  = status.valid && result_valid && result_stall;
    assign sample_accept = sample_valid && !sample_stall;

    esdc_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    esdc_window u_window (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_accept   (sample_accept),
        .adc_sample      (adc_sample),
        .reference_level (cfg.reference_level),
        .take            (take),
        .status          (status)
    );

    esdc_direction u_direction (
        .clk          (clk),
        .rst_n        (rst_n),
        .status       (status),
        .cfg          (cfg),
        .result_stall (result_stall),
        .take         (take),
        .result_valid (result_valid),
        .direction    (direction),
        .window_mean  (window_mean)
    );

endmodule

`default_nettype wire

[src/esdc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "eye_signal_direction_classifier_macros.svh"

module esdc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [esdc_pkg::PADDR_W-1:0]    paddr,
    input logic [esdc_pkg::PDATA_W-1:0]    pwdata,
    input logic [esdc_pkg::PDATA_W-1:0]    prdata,
    input logic                            pready,
    input logic                            sample_valid,
    input logic                            sample_stall,
    input logic [esdc_pkg::SAMPLE_W-1:0]   adc_sample,
    input logic                            result_valid,
    input logic                            result_stall,
    input logic [1:0]                      direction,
    input logic signed [7:0]               window_mean
);

    `ESDC_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(direction) && $stable(window_mean), "result changed while stalled")

    `ESDC_ASSERT_SAME(a_stall_cause, sample_stall, result_valid && result_stall, "input stalled without a stalled result")

    `ESDC_ASSERT_NEXT(a_clip_result, (sample_valid && !sample_stall && (adc_sample == esdc_pkg::ADC_MIN || adc_sample == esdc_pkg::ADC_MAX) && !result_valid) ##1 !result_valid, result_valid && direction == esdc_pkg::DIR_CLIP, "clipped sample did not give a clipping result")

    `ESDC_ASSERT_SAME(a_threshold_readback, (psel && penable && pwrite && pready && paddr[esdc_pkg::PADDR_W-1:2] == esdc_pkg::REG_THRESHOLD) ##1 (paddr[esdc_pkg::PADDR_W-1:2] == esdc_pkg::REG_THRESHOLD), prdata == esdc_pkg::PDATA_W'($past(pwdata[6:0])), "threshold read back differs from the value written")

endmodule

bind eye_signal_direction_classifier esdc_checker u_checker (.*);

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int MEAN_LOG2      = $clog2(esdc_pkg::WINDOW_DEPTH + 1) - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 166;
    localparam int DIRECTED_COUNT = 23;

    typedef struct packed {
        esdc_pkg::dir_t    dir;
        logic signed [7:0] mean;
    } eye_result_t;

    typedef struct packed {
        logic [7:0]        adc;
        bit                typed;
        esdc_pkg::dir_t    dir;
        logic signed [7:0] mean;
    } directed_row_t;

    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{8'd0,   1'b1, esdc_pkg::DIR_CLIP, 8'sd0},
        '{8'd255, 1'b1, esdc_pkg::DIR_CLIP, -8'sd1},
        '{8'd127, 1'b1, esdc_pkg::DIR_REST, 8'sd15},
        '{8'd127, 1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd127, 1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd127, 1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd127, 1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd100, 1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd128, 1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd128, 1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd128, 1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd128, 1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd128, 1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd128, 1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd128, 1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd128, 1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd0,   1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd1,   1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd1,   1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd254, 1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd254, 1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd254, 1'b0, esdc_pkg::DIR_REST, 8'sd0},
        '{8'd64,  1'b0, esdc_pkg::DIR_REST, 8'sd0}
    };

    logic                          clk;
    logic                          rst_n        = 1'b0;
    logic                          psel         = 1'b0;
    logic                          penable      = 1'b0;
    logic                          pwrite       = 1'b0;
    logic [esdc_pkg::PADDR_W-1:0]  paddr        = '0;
    logic [esdc_pkg::PDATA_W-1:0]  pwdata       = '0;
    logic [esdc_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;
    logic                          sample_valid = 1'b0;
    logic                          sample_stall;
    logic [esdc_pkg::SAMPLE_W-1:0] adc_sample   = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    logic [1:0]                    direction;
    logic signed [7:0]             window_mean;

    logic [7:0]        cfg_ref = esdc_pkg::REFERENCE_RESET;
    logic [6:0]        cfg_thr = esdc_pkg::THRESHOLD_RESET;
    logic [9:0]        cfg_tmo = esdc_pkg::TIMEOUT_RESET;
    logic signed [7:0] window_diffs [esdc_pkg::WINDOW_DEPTH];
    int                window_total = 0;
    int                window_slot  = 0;
    esdc_pkg::dir_t    last_class   = esdc_pkg::DIR_REST;
    esdc_pkg::dir_t    held_dir     = esdc_pkg::DIR_REST;
    logic [9:0]        hold_count   = '0;

    eye_result_t expected_directions [$];
    logic [7:0]  phase_samples [$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    bit          send_idle      = 1'b1;
    bit          recv_idle      = 1'b1;

    eye_signal_direction_classifier u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .adc_sample   (adc_sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .direction    (direction),
        .window_mean  (window_mean)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        foreach (window_diffs[i])
            window_diffs[i] = '0;
    end

    function automatic eye_result_t classify_sample(input logic [7:0] raw);
        logic [7:0]     diff;
        int             mean;
        int             thr;
        esdc_pkg::dir_t cls;
        esdc_pkg::dir_t dir;
        esdc_pkg::dir_t prior;
        eye_result_t    res;
        diff = raw - cfg_ref;
        window_total = window_total + int'($signed(diff)) - int'(window_diffs[window_slot]);
        window_diffs[window_slot] = $signed(diff);
        window_slot = (window_slot + 1) % esdc_pkg::WINDOW_DEPTH;
        mean = window_total >>> MEAN_LOG2;
        if (mean > 127)
            mean = 127;
        if (mean < -128)
            mean = -128;
        thr = cfg_thr;
        if (raw == esdc_pkg::ADC_MIN || raw == esdc_pkg::ADC_MAX)
            cls = esdc_pkg::DIR_CLIP;
        else if (mean > thr)
            cls = esdc_pkg::DIR_LEFT;
        else if (mean < -thr)
            cls = esdc_pkg::DIR_RIGHT;
        else
            cls = esdc_pkg::DIR_REST;
        prior = held_dir;
        dir = held_dir;
        if (cls == esdc_pkg::DIR_CLIP)
            dir = esdc_pkg::DIR_CLIP;
        else if (last_class == esdc_pkg::DIR_CLIP)
            dir = cls;
        else if (last_class == esdc_pkg::DIR_REST && cls == esdc_pkg::DIR_LEFT)
        begin
            if (prior == esdc_pkg::DIR_REST || prior == esdc_pkg::DIR_LEFT)
                dir = esdc_pkg::DIR_LEFT;
            else if (prior == esdc_pkg::DIR_RIGHT)
                dir = esdc_pkg::DIR_REST;
        end
        else if (last_class == esdc_pkg::DIR_REST && cls == esdc_pkg::DIR_RIGHT)
        begin
            if (prior == esdc_pkg::DIR_REST || prior == esdc_pkg::DIR_RIGHT)
                dir = esdc_pkg::DIR_RIGHT;
            else if (prior == esdc_pkg::DIR_LEFT)
                dir = esdc_pkg::DIR_REST;
        end
        last_class = cls;
        if (dir != prior)
            hold_count = '0;
        else if (hold_count == cfg_tmo)
        begin
            if (dir == esdc_pkg::DIR_LEFT || dir == esdc_pkg::DIR_RIGHT)
                dir = esdc_pkg::DIR_REST;
            hold_count = '0;
        end
        else
            hold_count = hold_count + 10'd1;
        held_dir = dir;
        res.dir = dir;
        res.mean = mean[7:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic send_sample(input logic [7:0] value, input bit typed,
                               input eye_result_t typed_res);
        int          gap;
        bit          accepted;
        eye_result_t res;
        gap = send_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        adc_sample <= value;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = !sample_stall;
            @(posedge clk);
        end
        res = classify_sample(value);
        expected_directions.push_back(typed ? typed_res : res);
    endtask

    task automatic drain_results();
        sample_valid <= 1'b0;
        while (expected_directions.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [esdc_pkg::REG_IDX_W-1:0] idx,
                                  input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            esdc_pkg::REG_REFERENCE_LEVEL: cfg_ref = value[7:0];
            esdc_pkg::REG_THRESHOLD:       cfg_thr = value[6:0];
            esdc_pkg::REG_TIMEOUT:         cfg_tmo = value[9:0];
            default:                       ;
        endcase
    endtask

    task automatic build_phase(input int count);
        int kind;
        int amp;
        int len;
        int noise;
        phase_samples.delete();
        while (phase_samples.size() < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                repeat ($urandom_range(1, 4))
                    phase_samples.push_back(($urandom_range(0, 1) != 0) ?
                                            esdc_pkg::ADC_MAX : esdc_pkg::ADC_MIN);
            end
            else if (kind == 1)
            begin
                repeat ($urandom_range(1, 6))
                    phase_samples.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                if ($urandom_range(0, 1) != 0)
                    amp = $urandom_range(0, 127);
                else
                    amp = -int'($urandom_range(1, 128));
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(40, 120);
                else
                    len = $urandom_range(1, 24);
                repeat (len)
                begin
                    noise = int'($urandom_range(0, 6)) - 3;
                    phase_samples.push_back(8'(int'(cfg_ref) + amp + noise));
                end
                repeat ($urandom_range(0, 30))
                begin
                    noise = int'($urandom_range(0, 6)) - 3;
                    phase_samples.push_back(8'(int'(cfg_ref) + noise));
                end
            end
        end
        while (phase_samples.size() > count)
            void'(phase_samples.pop_back());
    endtask

    initial
    begin : result_monitor
        int                n;
        bit                seen;
        logic [1:0]        got_dir;
        logic signed [7:0] got_mean;
        eye_result_t       want;
        forever
        begin
            n = recv_idle ? $urandom_range(0, 10) : 0;
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            seen = 1'b0;
            while (!seen)
            begin
                @(negedge clk);
                seen = result_valid;
                got_dir = direction;
                got_mean = window_mean;
                @(posedge clk);
            end
            if (expected_directions.size() == 0)
                report_mismatch($sformatf("unexpected transfer: direction %0d mean %0d",
                                          got_dir, got_mean));
            else
            begin
                want = expected_directions.pop_front();
                if (got_dir !== want.dir)
                    report_mismatch($sformatf("direction %0d, expected %0d",
                                              got_dir, want.dir));
                if (got_mean !== want.mean)
                    report_mismatch($sformatf("window_mean %0d, expected %0d",
                                              got_mean, want.mean));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int          p;
        int          ref_v;
        int          thr_v;
        int          tmo_v;
        eye_result_t typed_res;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (p = 0; p < DIRECTED_COUNT; p++)
        begin
            typed_res.dir = DIRECTED_ROWS[p].dir;
            typed_res.mean = DIRECTED_ROWS[p].mean;
            send_sample(DIRECTED_ROWS[p].adc, DIRECTED_ROWS[p].typed, typed_res);
        end

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:
                begin
                    ref_v = 128; thr_v = 20; tmo_v = 30;
                end
                1:
                begin
                    ref_v = 0; thr_v = 0; tmo_v = 0;
                end
                2:
                begin
                    ref_v = 255; thr_v = 127; tmo_v = 1023;
                end
                3:
                begin
                    ref_v = 128; thr_v = 10; tmo_v = 8;
                end
                default:
                begin
                    ref_v = $urandom_range(0, 255);
                    thr_v = $urandom_range(0, 60);
                    tmo_v = $urandom_range(0, 80);
                end
            endcase
            drain_results();
            write_register(esdc_pkg::REG_REFERENCE_LEVEL, ref_v);
            write_register(esdc_pkg::REG_THRESHOLD, thr_v);
            write_register(esdc_pkg::REG_TIMEOUT, tmo_v);
            send_idle = (p % 3 != 1);
            recv_idle = (p % 3 != 2);
            build_phase(PHASE_ITEMS);
            foreach (phase_samples[i])
                send_sample(phase_samples[i], 1'b0, typed_res);
        end

        sample_valid <= 1'b0;
        while (expected_directions.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
